/* hdl/swisc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// swisc_pkg: shared types and constants for the idle server counter
// Field widths, register codes, shared-unit opcodes and inter-module structs.
// ----------------------------------------------------------------------------
package swisc_pkg;

	// fixed field widths
	localparam int SID_W  = 10;
	localparam int TAG_W  = 16;
	localparam int NOS_W  = 11;
	localparam int WIN_W  = 24;
	localparam int IDLE_W = 11;
	localparam int CFG_W  = 24;
	localparam int CFG_IDX_W = 1;

	// result beat: idle_servers, result_tag, overflow_seen
	localparam int OUT_BITS = IDLE_W + TAG_W + 1;
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	// parameter defaults
	localparam int MAX_SERVERS_DEF = 1024;
	localparam int FIFO_DEPTH_DEF  = 1024;
	localparam int TIME_BITS_DEF   = 24;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_NUM_SERVERS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW      = 1'b1;

	localparam logic [NOS_W-1:0] NOS_RST = 11'd1024;
	localparam logic [WIN_W-1:0] WIN_RST = 24'd10;

	// command codes
	localparam logic CMD_REQUEST = 1'b0;
	localparam logic CMD_QUERY   = 1'b1;

	typedef enum logic {
		ALU_ADD = 1'b0,
		ALU_SUB = 1'b1
	} alu_op_t;

	typedef struct packed {
		logic borrow;   // a < b on subtract
		logic zero;     // result is zero
	} alu_flags_t;

	typedef struct packed {
		logic push;
		logic pop;
		logic rd;       // read the head entry
	} fifo_ctl_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

endpackage

`default_nettype wire

/* hdl/sliding_window_idle_server_count.sv */
// A request is queued and its count read, then bumped, and the active total too when
//   its server becomes active. A query checks the queue head and retires each expired
//   entry (dropping its count and, if the server idles, the active total), then waits
//   on a full result register. One beat at a time, via one shared adder and count port.
// Reset: asynchronous, active low. Afterwards the count store is swept to zero, one
//   entry per cycle, with s_axis_tready low; config writes still land.
`default_nettype none
// ----------------------------------------------------------------------------
// sliding_window_idle_server_count: idle servers over a sliding time window
// Requests are queued with their time and bump a per-server count; a query
// retires entries from the queue head while older than (query time - window), drops
// their servers' counts and returns number_of_servers minus active servers (min 0).
// ----------------------------------------------------------------------------
module sliding_window_idle_server_count import swisc_pkg::*; #(
	parameter int MAX_SERVERS = MAX_SERVERS_DEF,
	parameter int FIFO_DEPTH  = FIFO_DEPTH_DEF,
	parameter int TIME_BITS   = TIME_BITS_DEF,
	localparam int IN_BITS = SID_W + TIME_BITS + TAG_W,
	localparam int IN_W    = ((IN_BITS + 7) / 8) * 8
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// input beats
	input  wire logic                 s_axis_tvalid,
	output logic                      s_axis_tready,
	input  wire logic [IN_W-1:0]      s_axis_tdata,   // server_id, event_time, query_tag
	input  wire logic                 s_axis_tuser,   // command
	// result beats
	output logic                      m_axis_tvalid,
	input  wire logic                 m_axis_tready,
	output logic      [OUT_W-1:0]     m_axis_tdata,   // idle_servers, result_tag, overflow_seen
	// config writes
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);

	localparam int SRV_W = $clog2(MAX_SERVERS);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
	localparam int ACT_W = $clog2(MAX_SERVERS + 1);
	localparam int AW    = ((TIME_BITS > WIN_W) ? TIME_BITS : WIN_W) + 1;
	localparam int ENT_W = SRV_W + TIME_BITS;
	localparam logic [SRV_W-1:0] SRV_LAST = SRV_W'(MAX_SERVERS - 1);

	typedef enum logic [9:0] {
		S_CLEAR   = 10'b0000000001,
		S_IDLE    = 10'b0000000010,
		S_INC     = 10'b0000000100,
		S_ACT_INC = 10'b0000001000,
		S_Q_CHECK = 10'b0000010000,
		S_Q_SUM   = 10'b0000100000,
		S_Q_CMP   = 10'b0001000000,
		S_Q_DEC   = 10'b0010000000,
		S_Q_ACT   = 10'b0100000000,
		S_CALC    = 10'b1000000000
	} state_t;

	state_t state_q, state_d;

	// config registers
	logic [NOS_W-1:0] nos_q;
	logic [WIN_W-1:0] win_q;

	// latched beat and working registers
	logic [SRV_W-1:0]     sid_q;
	logic [TIME_BITS-1:0] t_q;
	logic [TAG_W-1:0]     tag_q;
	logic [SRV_W-1:0]     head_srv_q;
	logic [AW-1:0]        sum_q;
	logic [ACT_W-1:0]     active_q;
	logic                 ovf_q;
	logic [SRV_W-1:0]     clr_q;

	// output register
	logic               out_valid_q;
	logic [OUT_W-1:0]   out_data_q;
	logic               out_free;
	logic               out_load;

	// input field split
	logic [SID_W-1:0]     in_sid;
	logic [TIME_BITS-1:0] in_time;
	logic [TAG_W-1:0]     in_tag;
	logic [SRV_W-1:0]     in_idx;
	logic                 in_range;
	logic                 in_fire;

	assign in_sid   = s_axis_tdata[SID_W-1:0];
	assign in_time  = s_axis_tdata[SID_W +: TIME_BITS];
	assign in_tag   = s_axis_tdata[SID_W + TIME_BITS +: TAG_W];
	assign in_idx   = SRV_W'(in_sid);
	assign in_range = (32'(in_sid) < MAX_SERVERS);

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	// ------------------------------------------------------------------
	// event queue
	// ------------------------------------------------------------------
	fifo_ctl_t        fifo_ctl;
	fifo_stat_t       fifo_stat;
	logic [ENT_W-1:0] fifo_rd;
	logic [ENT_W-1:0] fifo_wr;
	logic [TIME_BITS-1:0] head_time;

	// entry layout: time in the low bits, server above
	assign fifo_wr   = {in_idx, in_time};
	assign head_time = fifo_rd[TIME_BITS-1:0];

	swisc_event_fifo #(
		.DEPTH (FIFO_DEPTH),
		.ENT_W (ENT_W)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (fifo_ctl),
		.wr_data (fifo_wr),
		.rd_data (fifo_rd),
		.stat    (fifo_stat)
	);

	// ------------------------------------------------------------------
	// per-server counts
	// ------------------------------------------------------------------
	logic             cnt_we;
	logic [SRV_W-1:0] cnt_waddr;
	logic [CNT_W-1:0] cnt_wdata;
	logic             cnt_re;
	logic [SRV_W-1:0] cnt_raddr;
	logic [CNT_W-1:0] cnt_rdata;

	swisc_count_store #(
		.DEPTH (MAX_SERVERS),
		.CNT_W (CNT_W)
	) u_counts (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.re    (cnt_re),
		.raddr (cnt_raddr),
		.rdata (cnt_rdata)
	);

	// ------------------------------------------------------------------
	// shared adder
	// ------------------------------------------------------------------
	logic [AW-1:0] alu_a;
	logic [AW-1:0] alu_b;
	alu_op_t       alu_op;
	logic [AW-1:0] alu_res;
	alu_flags_t    alu_flags;

	swisc_alu #(
		.AW (AW)
	) u_alu (
		.a     (alu_a),
		.b     (alu_b),
		.op    (alu_op),
		.res   (alu_res),
		.flags (alu_flags)
	);

	assign out_free = !out_valid_q || m_axis_tready;
	assign out_load = (state_q == S_CALC) && out_free;

	// ------------------------------------------------------------------
	// sequencer
	// ------------------------------------------------------------------
	always_comb begin
		state_d   = state_q;
		fifo_ctl  = '0;
		cnt_we    = 1'b0;
		cnt_waddr = sid_q;
		cnt_wdata = alu_res[CNT_W-1:0];
		cnt_re    = 1'b0;
		cnt_raddr = in_idx;
		alu_a     = '0;
		alu_b     = '0;
		alu_op    = ALU_ADD;

		case (state_q)
			S_CLEAR: begin
				cnt_we    = 1'b1;
				cnt_waddr = clr_q;
				cnt_wdata = '0;
				if (clr_q == SRV_LAST) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_fire) begin
					if (s_axis_tuser == CMD_QUERY) begin
						state_d = S_Q_CHECK;
					end else if (in_range && !fifo_stat.full) begin
						// queue the request and fetch its count
						fifo_ctl.push = 1'b1;
						cnt_re        = 1'b1;
						state_d       = S_INC;
					end
				end
			end
			S_INC: begin
				alu_a  = AW'(cnt_rdata);
				alu_b  = AW'(1'b1);
				cnt_we = 1'b1;
				// count going from zero to one activates the server
				state_d = (cnt_rdata == '0) ? S_ACT_INC : S_IDLE;
			end
			S_ACT_INC: begin
				alu_a   = AW'(active_q);
				alu_b   = AW'(1'b1);
				state_d = S_IDLE;
			end
			S_Q_CHECK: begin
				if (fifo_stat.empty) begin
					state_d = S_CALC;
				end else begin
					fifo_ctl.rd = 1'b1;
					state_d     = S_Q_SUM;
				end
			end
			S_Q_SUM: begin
				alu_a   = AW'(head_time);
				alu_b   = AW'(win_q);
				state_d = S_Q_CMP;
			end
			S_Q_CMP: begin
				// head expired when head time + window < query time
				alu_a     = sum_q;
				alu_b     = AW'(t_q);
				alu_op    = ALU_SUB;
				cnt_raddr = head_srv_q;
				if (alu_flags.borrow) begin
					cnt_re  = 1'b1;
					state_d = S_Q_DEC;
				end else begin
					state_d = S_CALC;
				end
			end
			S_Q_DEC: begin
				alu_a        = AW'(cnt_rdata);
				alu_b        = AW'(1'b1);
				alu_op       = ALU_SUB;
				cnt_waddr    = head_srv_q;
				fifo_ctl.pop = 1'b1;
				state_d      = S_Q_CHECK;
				if (cnt_rdata != '0) begin
					cnt_we = 1'b1;
					if (alu_flags.zero && (active_q != '0)) begin
						state_d = S_Q_ACT;
					end
				end
			end
			S_Q_ACT: begin
				alu_a   = AW'(active_q);
				alu_b   = AW'(1'b1);
				alu_op  = ALU_SUB;
				state_d = S_Q_CHECK;
			end
			S_CALC: begin
				alu_a  = AW'(nos_q);
				alu_b  = AW'(active_q);
				alu_op = ALU_SUB;
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			active_q    <= '0;
			ovf_q       <= 1'b0;
			nos_q       <= NOS_RST;
			win_q       <= WIN_RST;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end

			if ((state_q == S_ACT_INC) || (state_q == S_Q_ACT)) begin
				active_q <= alu_res[ACT_W-1:0];
			end

			// full queue: request dropped, flag sticks until reset
			if (in_fire && (s_axis_tuser == CMD_REQUEST) && in_range && fifo_stat.full) begin
				ovf_q <= 1'b1;
			end

			if (cfg_we) begin
				case (cfg_index)
					REG_NUM_SERVERS: nos_q <= cfg_data[NOS_W-1:0];
					REG_WINDOW:      win_q <= cfg_data[WIN_W-1:0];
					default: begin
					end
				endcase
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			sid_q <= in_idx;
			t_q   <= in_time;
			tag_q <= in_tag;
		end
		if (state_q == S_Q_SUM) begin
			head_srv_q <= fifo_rd[TIME_BITS +: SRV_W];
			sum_q      <= alu_res;
		end
		if (out_load) begin
			// saturate at zero when active exceeds the configured total
			out_data_q <= OUT_W'({ovf_q, tag_q,
				alu_flags.borrow ? {IDLE_W{1'b0}} : alu_res[IDLE_W-1:0]});
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

`ifndef SYNTHESIS
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_ctl.pop |-> !fifo_stat.empty)
		else $error("queue popped while empty");

	a_result_from_calc: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q == S_CALC))
		else $error("result beat raised outside the result step");

	a_active_dec_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_Q_ACT) |-> (active_q != '0))
		else $error("active total decremented from zero");
`endif

endmodule

`default_nettype wire

/* hdl/swisc_alu.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// swisc_alu: shared add/subtract unit
// One adder used for time sums, expiry compares, count and total updates and the idle result.
// ----------------------------------------------------------------------------
module swisc_alu import swisc_pkg::*; #(
	parameter int AW = 25
) (
	input  wire logic [AW-1:0] a,
	input  wire logic [AW-1:0] b,
	input  wire alu_op_t       op,
	output logic [AW-1:0]      res,
	output alu_flags_t         flags
);

	logic [AW:0]   sum;
	logic [AW-1:0] b_eff;
	logic          sub;

	assign sub   = (op == ALU_SUB);
	assign b_eff = sub ? ~b : b;
	assign sum   = {1'b0, a} + {1'b0, b_eff} + {{AW{1'b0}}, sub};

	assign res          = sum[AW-1:0];
	assign flags.borrow = sub & ~sum[AW];
	assign flags.zero   = (sum[AW-1:0] == '0);

endmodule

`default_nettype wire

/* hdl/swisc_event_fifo.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// swisc_event_fifo: request event queue
// Circular buffer of {server, time}; registered read of the head entry.
// ----------------------------------------------------------------------------
module swisc_event_fifo import swisc_pkg::*; #(
	parameter int DEPTH = FIFO_DEPTH_DEF,
	parameter int ENT_W = 34
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire fifo_ctl_t        ctl,
	input  wire logic [ENT_W-1:0] wr_data,
	output logic      [ENT_W-1:0] rd_data,
	output fifo_stat_t            stat
);

	localparam int PTR_W  = $clog2(DEPTH);
	localparam int FILL_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(DEPTH);

	logic [ENT_W-1:0]  mem [DEPTH];
	logic [PTR_W-1:0]  head_q;
	logic [PTR_W-1:0]  tail_q;
	logic [FILL_W-1:0] fill_q;

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			mem[tail_q] <= wr_data;
		end
		if (ctl.rd) begin
			rd_data <= mem[head_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			fill_q <= '0;
		end else begin
			if (ctl.push) begin
				tail_q <= (tail_q == PTR_LAST) ? '0 : tail_q + 1'b1;
			end
			if (ctl.pop) begin
				head_q <= (head_q == PTR_LAST) ? '0 : head_q + 1'b1;
			end
			if (ctl.push && !ctl.pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (ctl.pop && !ctl.push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	assign stat.full  = (fill_q == FILL_MAX);
	assign stat.empty = (fill_q == '0);

endmodule

`default_nettype wire

/* hdl/swisc_count_store.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// swisc_count_store: per-server request counts
// Single write port, single registered read port; cleared by the sequencer.
// ----------------------------------------------------------------------------
module swisc_count_store import swisc_pkg::*; #(
	parameter int DEPTH = MAX_SERVERS_DEF,
	parameter int CNT_W = 11
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [CNT_W-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [CNT_W-1:0]         rdata
);

	logic [CNT_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

/* verif/sliding_window_idle_server_count_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_idle_server_count_tb: self-checking bench for the idle counter
// Streams request and query beats at random pacing, keeps its own copy of the
// request queue and per-server counts, and checks every result beat in order.
// ----------------------------------------------------------------------------
import swisc_pkg::*;

typedef struct {
	bit [SID_W-1:0] sid;
	bit [23:0]      stamp;
} logged_request_t;

typedef struct {
	bit [IDLE_W-1:0] idle;
	bit [TAG_W-1:0]  tag;
	bit              ovf;
} idle_report_t;

class idle_count_scoreboard;
	bit [10:0]       req_count[MAX_SERVERS_DEF];
	logged_request_t request_log[$];
	bit [10:0]       active_servers;
	bit              overflow_seen;
	bit [NOS_W-1:0]  server_total;
	bit [WIN_W-1:0]  window;
	idle_report_t    pending_reports[$];
	int              mismatches;

	function new();
		foreach (req_count[i])
			req_count[i] = '0;
		active_servers = '0;
		overflow_seen  = 1'b0;
		server_total   = NOS_RST;
		window         = WIN_RST;
		mismatches     = 0;
	endfunction

	function void set_register(bit [CFG_IDX_W-1:0] idx, bit [CFG_W-1:0] val);
		if (idx == REG_NUM_SERVERS)
			server_total = val[NOS_W-1:0];
		else
			window = val[WIN_W-1:0];
	endfunction

	function void note_failure(string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s", $realtime, msg);
	endfunction

	// one accepted input beat: update the model and queue any result it makes
	function void log_event(bit cmd, bit [SID_W-1:0] sid, bit [23:0] stamp,
		bit [TAG_W-1:0] tag);
		logged_request_t head;
		idle_report_t    rpt;
		if (cmd == CMD_REQUEST) begin
			if (request_log.size() >= FIFO_DEPTH_DEF) begin
				overflow_seen = 1'b1;
				return;
			end
			head.sid   = sid;
			head.stamp = stamp;
			request_log.insert(request_log.size(), head);
			req_count[sid]++;
			if (req_count[sid] == 11'd1)
				active_servers++;
			return;
		end
		// retire from the head only; stop at the first live entry
		while (request_log.size() > 0) begin
			head = request_log[0];
			if ({1'b0, head.stamp} + {1'b0, window} >= {1'b0, stamp})
				break;
			if (req_count[head.sid] != '0) begin
				req_count[head.sid]--;
				if (req_count[head.sid] == '0 && active_servers != '0)
					active_servers--;
			end
			void'(request_log.pop_front());
		end
		rpt.idle = (server_total > active_servers) ? server_total - active_servers : '0;
		rpt.tag  = tag;
		rpt.ovf  = overflow_seen;
		pending_reports.insert(pending_reports.size(), rpt);
	endfunction

	function void check_result(bit [IDLE_W-1:0] idle, bit [TAG_W-1:0] tag, bit ovf);
		idle_report_t want;
		if (pending_reports.size() == 0) begin
			note_failure($sformatf("result beat with none pending: idle=%0d tag=%h ovf=%b",
				idle, tag, ovf));
			return;
		end
		want = pending_reports.pop_front();
		if (want.idle != idle || want.tag != tag || want.ovf != ovf)
			note_failure($sformatf({"result mismatch: exp idle=%0d tag=%h ovf=%b, ",
				"got idle=%0d tag=%h ovf=%b"},
				want.idle, want.tag, want.ovf, idle, tag, ovf));
	endfunction

	// leftover expectations count as failures too
	function int failures();
		return mismatches + pending_reports.size();
	endfunction
endclass

module sliding_window_idle_server_count_tb;

	localparam int IN_BITS  = SID_W + 24 + TAG_W;
	localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
	localparam bit [23:0] T_MAX = 24'hFFFFFF;

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [IN_W-1:0]      s_axis_tdata = '0;   // server_id, event_time, query_tag
	logic                 s_axis_tuser = 1'b0; // command
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [OUT_W-1:0]     m_axis_tdata;        // idle_servers, result_tag, overflow_seen
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	idle_count_scoreboard sb;

	// stall odds in percent, changed by the stimulus as the run goes on
	int unsigned tx_idle_pct = 13;
	int unsigned rx_idle_pct = 61;

	// running event time; requests and queries mostly move it forward
	bit [23:0] t_now = '0;

	sliding_window_idle_server_count dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver back-pressure
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99, 0) >= rx_idle_pct);
	end

	// result monitor: values sampled are those in place at the edge
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata[IDLE_W-1:0], m_axis_tdata[IDLE_W +: TAG_W],
				m_axis_tdata[IDLE_W+TAG_W]);
	end

	// One input beat. Returns at the edge where it was taken; tvalid stays high
	// so a following beat goes out back to back unless a gap is rolled.
	task automatic send_beat(input logic cmd, input logic [SID_W-1:0] sid,
		input logic [23:0] stamp, input logic [TAG_W-1:0] tag);
		while ($urandom_range(99, 0) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= cmd;
		s_axis_tdata  <= {{(IN_W-IN_BITS){1'b0}}, tag, stamp, sid};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		sb.log_event(cmd, sid, stamp, tag);
	endtask

	// Drop tvalid, let every pending result drain, then let the block finish up before
	// anything else is touched.
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (sb.pending_reports.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// both registers back to back, with cfg_we held high across the two writes
	task automatic write_regs(input bit [NOS_W-1:0] nos, input bit [WIN_W-1:0] win);
		cfg_we    <= 1'b1;
		cfg_index <= REG_NUM_SERVERS;
		cfg_data  <= CFG_W'(nos);
		@(posedge clk);
		sb.set_register(REG_NUM_SERVERS, CFG_W'(nos));
		cfg_index <= REG_WINDOW;
		cfg_data  <= CFG_W'(win);
		@(posedge clk);
		sb.set_register(REG_WINDOW, CFG_W'(win));
		cfg_we <= 1'b0;
	endtask

	// steps stay well under 2^24, so the narrowing is lossless
	function automatic bit [23:0] advance_time(bit [23:0] t, int unsigned step);
		return (t > T_MAX - 24'(step)) ? T_MAX : t + 24'(step);
	endfunction

	// Random phase: mostly forward-moving time with about 30% queries, a few
	// beats stamped slightly in the past. Always closes with a query so the
	// block is known idle once its result is back.
	task automatic random_phase(input bit [NOS_W-1:0] nos, input bit [WIN_W-1:0] win,
		input int unsigned sid_hi, input int unsigned step_max, input bit [23:0] base,
		input int n_items);
		bit             is_query;
		bit [23:0]      stamp;
		int unsigned    back;
		wait_drained();
		write_regs(nos, win);
		if (base > t_now)
			t_now = advance_time(base, $urandom_range(16'hFFFF, 0));
		for (int i = 0; i < n_items; i++) begin
			is_query = ($urandom_range(99, 0) < 30) || (i == n_items - 1);
			if ($urandom_range(99, 0) < 6) begin
				back  = $urandom_range(step_max + 1, 0);
				stamp = (t_now > back) ? t_now - 24'(back) : '0;
			end else begin
				t_now = advance_time(t_now, $urandom_range(step_max, 0));
				stamp = t_now;
			end
			send_beat(is_query ? CMD_QUERY : CMD_REQUEST, SID_W'($urandom_range(sid_hi, 0)),
				stamp, TAG_W'($urandom));
		end
	endtask

	initial begin
		sb = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// --- directed, reset config: 1024 servers, window 10 ---
		send_beat(CMD_QUERY,   10'd0,    24'd0,   16'h0000);   // empty queue
		send_beat(CMD_REQUEST, 10'd0,    24'd0,   16'h1234);
		send_beat(CMD_REQUEST, 10'd1023, 24'd0,   16'hFFFF);
		send_beat(CMD_REQUEST, 10'd0,    24'd1,   16'h0000);   // second hit, same server
		send_beat(CMD_REQUEST, 10'd5,    24'd5,   16'h0001);
		send_beat(CMD_QUERY,   10'd1023, 24'd10,  16'hFFFF);   // boundary: nothing expires
		send_beat(CMD_QUERY,   10'd0,    24'd11,  16'h0002);   // both t=0 entries go
		send_beat(CMD_REQUEST, 10'd7,    24'd20,  16'h0003);
		send_beat(CMD_QUERY,   10'd0,    24'd20,  16'h0004);   // request ahead of query, same time
		send_beat(CMD_REQUEST, 10'd300,  24'd200, 16'h0005);
		send_beat(CMD_REQUEST, 10'd301,  24'd150, 16'h0006);   // out of order, stuck behind head
		send_beat(CMD_QUERY,   10'd0,    24'd205, 16'h0007);
		send_beat(CMD_QUERY,   10'd0,    24'd300, 16'h0008);   // everything retires

		// --- one server, widest window: idle count floors at zero ---
		wait_drained();
		write_regs(11'd1, 24'hFFFFFF);
		for (int i = 0; i < 5; i++)
			send_beat(CMD_REQUEST, SID_W'(1 + i % 4), 24'(400 + i), TAG_W'(16 + i));
		send_beat(CMD_QUERY, 10'd0, 24'h000500, 16'hA5A5);
		t_now = 24'h000500;

		// --- random phases; pacing regime moves along with them ---
		random_phase(11'd1024, 24'd1,        1023, 3,    24'h000600, 70);
		random_phase(11'd37,   24'd50,       63,   20,   24'h1C0000, 70);
		random_phase(11'd1024, 24'hFFFFFF,   1023, 100,  24'h380000, 70);
		tx_idle_pct = 61;
		rx_idle_pct = 13;
		random_phase(11'd1,    24'd1,        3,    2,    24'h540000, 70);
		random_phase(11'd600,  24'd1000,     1023, 400,  24'h700000, 70);
		random_phase(11'd8,    24'd200,      15,   80,   24'h8C0000, 70);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		random_phase(11'd1024, 24'd5000,     255,  3000, 24'hA80000, 70);
		random_phase(11'd250,  24'd12,       31,   6,    24'hC40000, 70);

		// --- near the top of the time range ---
		random_phase(11'd1024, 24'd1, 1023, 2, 24'hFF0000, 20);
		send_beat(CMD_QUERY, 10'h3FF, T_MAX, 16'hFFFF);

		wait_drained();
		if (sb.failures() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#3_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
